[rtl/core/assert_macros.svh]
// Assertion macros used by the checker module of the block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/bslp_pkg.sv]
// Types and constants of the button press detector.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bslp_pkg;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_code_type;

   localparam int DEBOUNCE_W  = 8;
   localparam int TICK_W      = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_DEBOUNCE_TICKS = 3'd0;
   localparam csr_index_type CSR_LONG_TICKS     = 3'd1;
   localparam csr_index_type CSR_LONG_LIMIT     = 3'd2;
   localparam csr_index_type CSR_DOUBLE_WINDOW  = 3'd3;
   localparam csr_index_type CSR_DOUBLE_ENABLE  = 3'd4;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET      = 8'd3;
   localparam logic [TICK_W-1:0]     LONG_TICKS_RESET    = 12'd100;
   localparam logic [TICK_W-1:0]     LONG_LIMIT_RESET    = 12'd400;
   localparam logic [TICK_W-1:0]     DOUBLE_WINDOW_RESET = 12'd50;
   localparam logic                  DOUBLE_ENABLE_RESET = 1'b1;

endpackage

[rtl/core/bslp_if.sv]
// Request and response channel interfaces of the button press detector.
// Depends on bslp_pkg for the event code type.
`timescale 1ns / 1ps

interface bslp_req_if;
   logic valid;
   logic ready;
   logic key_level;

   modport source (output valid, output key_level, input ready);
   modport sink (input valid, input key_level, output ready);
endinterface

interface bslp_rsp_if;
   logic                     valid;
   logic                     ready;
   bslp_pkg::event_code_type event_code;

   modport source (output valid, output event_code, input ready);
   modport sink (input valid, input event_code, output ready);
endinterface

[rtl/core/button_short_long_double_press.sv]
// Top level of the button short, long and double press detector.
// Depends on bslp_pkg and the channel interfaces in bslp_if.sv.
//
// Each request is one scan tick carrying the active-low button level and
// gives exactly one response with an event code (none, short, long,
// double). The debounce, hold and double-click state is updated in the
// cycle of acceptance and the code lands in an output register, so the
// response shows in the next cycle. A new request is taken in any cycle in
// which the output register is empty or its response is taken, so ticks
// run back to back at one request per cycle; a stalled response holds the
// request channel until it is taken. The user must write the registers
// only while no response is pending; the block does not enforce this.
`timescale 1ns / 1ps

module button_short_long_double_press #(
   parameter int TIMER_WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   bslp_req_if.sink                 req_if,
   bslp_rsp_if.source               rsp_if,
   input  logic                     csr_write_en,
   input  bslp_pkg::csr_index_type  csr_index,
   input  bslp_pkg::csr_data_type   csr_write_data
);
   import bslp_pkg::*;

   localparam int HOLD_W = TIMER_WIDTH + 1;
   localparam int CMP_W  = (HOLD_W > TICK_W) ? HOLD_W : TICK_W;
   localparam int WIN_W  = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [TICK_W-1:0]     long_ticks_ff;
   logic [TICK_W-1:0]     long_limit_ff;
   logic [TICK_W-1:0]     window_cfg_ff;
   logic                  double_en_ff;

   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic                   press_valid_ff, press_valid_in;
   logic                   expired_ff, expired_in;
   logic                   awaiting_ff, awaiting_in;
   logic [TIMER_WIDTH-1:0] window_ff, window_in;

   logic           rsp_valid_ff;
   event_code_type event_ff, event_in;

   logic                   req_accept;
   logic [CMP_W-1:0]       hold_cmp, held_cmp, debounce_cmp, long_ticks_cmp, long_limit_cmp;
   logic [WIN_W-1:0]       window_ext;
   logic [TIMER_WIDTH-1:0] window_load;

   assign req_if.ready     = !rsp_valid_ff || rsp_if.ready;
   assign req_accept       = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.event_code = event_ff;

   assign hold_cmp       = CMP_W'(hold_ff);
   assign debounce_cmp   = CMP_W'(debounce_ff);
   assign long_ticks_cmp = CMP_W'(long_ticks_ff);
   assign long_limit_cmp = CMP_W'(long_limit_ff);
   assign window_ext     = WIN_W'(window_cfg_ff);
   assign window_load    = window_ext[TIMER_WIDTH-1:0];

   always_comb begin
      hold_in        = hold_ff;
      press_valid_in = press_valid_ff;
      expired_in     = expired_ff;
      awaiting_in    = awaiting_ff;
      window_in      = window_ff;
      event_in       = EV_NONE;
      held_cmp       = hold_cmp;

      if (!req_if.key_level) begin
         if (!press_valid_ff) begin
            if (hold_cmp < debounce_cmp) begin
               hold_in = hold_ff + 1'b1;
            end
            held_cmp = CMP_W'(hold_in);
            if (held_cmp >= debounce_cmp) begin
               press_valid_in = 1'b1;
            end
         end else if (!expired_ff) begin
            if (hold_ff != '1) begin
               hold_in = hold_ff + 1'b1;
            end
            held_cmp = CMP_W'(hold_in);
            if (held_cmp >= long_ticks_cmp && held_cmp <= long_limit_cmp) begin
               event_in = EV_LONG;
            end else if (held_cmp > long_limit_cmp) begin
               expired_in = 1'b1;
            end
         end else begin
            press_valid_in = 1'b0;
            hold_in        = '0;
         end
      end else begin
         if (press_valid_ff && hold_cmp < long_ticks_cmp) begin
            if (!double_en_ff) begin
               event_in = EV_SHORT;
            end else if (awaiting_ff) begin
               awaiting_in = 1'b0;
               window_in   = '0;
               event_in    = EV_DOUBLE;
            end else begin
               awaiting_in = 1'b1;
               window_in   = window_load;
            end
         end
         hold_in        = '0;
         press_valid_in = 1'b0;
         expired_in     = 1'b0;
      end

      if (event_in == EV_NONE && window_in != '0) begin
         window_in = window_in - 1'b1;
         if (window_in == '0) begin
            awaiting_in = 1'b0;
            event_in    = EV_SHORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_ticks_ff <= LONG_TICKS_RESET;
         long_limit_ff <= LONG_LIMIT_RESET;
         window_cfg_ff <= DOUBLE_WINDOW_RESET;
         double_en_ff  <= DOUBLE_ENABLE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ff   <= csr_write_data[DEBOUNCE_W-1:0];
            CSR_LONG_TICKS:     long_ticks_ff <= csr_write_data[TICK_W-1:0];
            CSR_LONG_LIMIT:     long_limit_ff <= csr_write_data[TICK_W-1:0];
            CSR_DOUBLE_WINDOW:  window_cfg_ff <= csr_write_data[TICK_W-1:0];
            CSR_DOUBLE_ENABLE:  double_en_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff        <= '0;
         press_valid_ff <= 1'b0;
         expired_ff     <= 1'b0;
         awaiting_ff    <= 1'b0;
         window_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            hold_ff        <= hold_in;
            press_valid_ff <= press_valid_in;
            expired_ff     <= expired_in;
            awaiting_ff    <= awaiting_in;
            window_ff      <= window_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         event_ff <= event_in;
      end
   end

endmodule

[rtl/core/bslp_checker.sv]
// Port-level checker for the button press detector, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bslp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] event_code
);

   logic req_accept;
   logic rsp_stall;

   assign req_accept = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_accept_gives_rsp, clock, reset, req_accept, rsp_valid)
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_SAME(a_rsp_has_cause, clock, reset, rsp_valid, $past(req_accept) || $past(rsp_stall))
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid && $stable(event_code))

endmodule

bind button_short_long_double_press bslp_checker u_bslp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .event_code (rsp_if.event_code)
);
